// File: rtl/core/surt_pkg.sv
package surt_pkg;

    localparam int DEST_W   = 16;
    localparam int CNT_IN_W = 8;
    localparam int POS_W    = 8;
    localparam int RND_W    = 3;
    localparam int STAT_W   = 3;

    typedef logic [1:0]          cmd_t;
    typedef logic [DEST_W-1:0]   node_t;
    typedef logic [CNT_IN_W-1:0] count_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [RND_W-1:0]    rnd_t;
    typedef logic [STAT_W-1:0]   status_t;

    localparam cmd_t CMD_INSTALL = 2'd0;
    localparam cmd_t CMD_RELAY   = 2'd1;
    localparam cmd_t CMD_LOOKUP  = 2'd2;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_BAD     = 3'd1;
    localparam status_t ST_NOROUTE = 3'd2;
    localparam status_t ST_EMPTY   = 3'd3;
    localparam status_t ST_RELAY   = 3'd4;

endpackage

// File: rtl/core/surt_if.sv
interface surt_req_if
    import surt_pkg::*;
();
    logic   valid;
    logic   ready;
    cmd_t   cmd;
    node_t  dest_node;
    count_t relay_count;
    pos_t   relay_position;
    node_t  relay_addr;
    rnd_t   random_slot;

    modport source (
        output valid, cmd, dest_node, relay_count, relay_position, relay_addr, random_slot,
        input  ready
    );
    modport sink (
        input  valid, cmd, dest_node, relay_count, relay_position, relay_addr, random_slot,
        output ready
    );
endinterface

interface surt_rsp_if
    import surt_pkg::*;
();
    logic       valid;
    logic       ready;
    status_t    status;
    logic [3:0] relay_count_res;
    logic [2:0] last_relay_index;
    node_t      relay_addr_res;
    logic       last;

    modport source (
        output valid, status, relay_count_res, last_relay_index, relay_addr_res, last,
        input  ready
    );
    modport sink (
        input  valid, status, relay_count_res, last_relay_index, relay_addr_res, last,
        output ready
    );
endinterface

// File: rtl/core/single_use_source_route_table_top.sv
// Relay word, rejected install, unknown command: result built in EXEC, output in EMIT.
// Install and lookup: a slot scan through the slot memory read port, which stops at the
// first active slot with a matching destination, then FIN and EMIT to the first result.
// A consumed route streams its relays, each through relay memory read, capture and emit.
// One beat at a time; the next beat is accepted as soon as the last result is registered.
// Reset clears the active bits and the open slot at once; table contents need no clearing.
module single_use_source_route_table_top
    import surt_pkg::*;
#(
    parameter int ROUTE_SLOTS = 8,
    parameter int MAX_RELAYS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    surt_req_if.sink   req,
    surt_rsp_if.source rsp
);

    localparam int SW  = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_RELAYS + 1);
    localparam int RD  = ROUTE_SLOTS * MAX_RELAYS;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
    localparam int EW  = DEST_W + CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_RREAD = 3'd5;
    localparam logic [2:0] S_RDATA = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [ROUTE_SLOTS-1:0] active_reg, active_next;
    logic [SW-1:0]          open_slot_reg, open_slot_next;
    logic                   open_valid_reg, open_valid_next;
    logic [CW-1:0]          open_count_reg, open_count_next;
    logic [SW:0]            issue_idx_reg, issue_idx_next;
    logic                   chk_v_reg, chk_v_next;
    logic [SW-1:0]          chk_idx_reg, chk_idx_next;
    logic [SW-1:0]          pick_reg, pick_next;
    logic                   found_reg, found_next;
    logic [CW-1:0]          hit_cnt_reg, hit_cnt_next;
    logic [CW-1:0]          k_reg, k_next;
    logic                   more_reg, more_next;
    logic                   out_valid_reg, out_valid_next;

    cmd_t       cmd_reg, cmd_next;
    node_t      dest_reg, dest_next;
    count_t     count_reg, count_next;
    pos_t       pos_reg, pos_next;
    node_t      addr_reg, addr_next;
    rnd_t       rnd_reg, rnd_next;

    status_t    res_status_reg, res_status_next;
    logic [3:0] res_cnt_reg, res_cnt_next;
    logic [2:0] res_li_reg, res_li_next;
    node_t      res_addr_reg, res_addr_next;
    logic       res_last_reg, res_last_next;

    status_t    out_status_reg, out_status_next;
    logic [3:0] out_cnt_reg, out_cnt_next;
    logic [2:0] out_li_reg, out_li_next;
    node_t      out_addr_reg, out_addr_next;
    logic       out_last_reg, out_last_next;

    logic           slot_we;
    logic [SW-1:0]  slot_waddr;
    logic [EW-1:0]  slot_wdata;
    logic           slot_re;
    logic [EW-1:0]  slot_rdata;
    logic           relay_we;
    logic [RAW-1:0] relay_waddr;
    logic           relay_re;
    logic [RAW-1:0] relay_raddr;
    node_t          relay_rdata;

    node_t          rd_dest;
    logic [CW-1:0]  rd_cnt;
    logic           chk_act;
    logic           chk_match;
    logic           chk_last;
    logic           out_free;
    logic           relay_ok;
    logic [6:0]     rnd_mod;

    surt_ram #(
        .DEPTH (ROUTE_SLOTS),
        .WIDTH (EW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (issue_idx_reg[SW-1:0]),
        .rdata (slot_rdata)
    );

    surt_ram #(
        .DEPTH (RD),
        .WIDTH (DEST_W)
    ) u_relay_ram (
        .clk   (clk),
        .we    (relay_we),
        .waddr (relay_waddr),
        .wdata (addr_reg),
        .re    (relay_re),
        .raddr (relay_raddr),
        .rdata (relay_rdata)
    );

    assign rd_dest   = slot_rdata[EW-1:CW];
    assign rd_cnt    = slot_rdata[CW-1:0];
    assign chk_act   = active_reg[chk_idx_reg];
    assign chk_match = chk_act && (rd_dest == dest_reg);
    assign chk_last  = (chk_idx_reg == SW'(ROUTE_SLOTS - 1));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign relay_ok  = open_valid_reg && (pos_reg < POS_W'(open_count_reg))
                       && (pos_reg < POS_W'(MAX_RELAYS));

    assign slot_waddr  = pick_reg;
    assign slot_wdata  = {dest_reg, CW'(count_reg)};
    assign relay_waddr = RAW'(open_slot_reg) * RAW'(MAX_RELAYS) + RAW'(pos_reg);
    assign relay_raddr = RAW'(pick_reg) * RAW'(MAX_RELAYS) + RAW'(k_reg - 1'b1);

    always_comb
    begin
        rnd_mod = 7'(rnd_reg);
        for (int j = 0; j < 8; j++)
        begin
            if (rnd_mod >= 7'(ROUTE_SLOTS))
            begin
                rnd_mod = rnd_mod - 7'(ROUTE_SLOTS);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        open_slot_next  = open_slot_reg;
        open_valid_next = open_valid_reg;
        open_count_next = open_count_reg;
        issue_idx_next  = issue_idx_reg;
        chk_v_next      = 1'b0;
        chk_idx_next    = chk_idx_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        hit_cnt_next    = hit_cnt_reg;
        k_next          = k_reg;
        more_next       = more_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        dest_next       = dest_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        addr_next       = addr_reg;
        rnd_next        = rnd_reg;
        res_status_next = res_status_reg;
        res_cnt_next    = res_cnt_reg;
        res_li_next     = res_li_reg;
        res_addr_next   = res_addr_reg;
        res_last_next   = res_last_reg;
        out_status_next = out_status_reg;
        out_cnt_next    = out_cnt_reg;
        out_li_next     = out_li_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        slot_we         = 1'b0;
        slot_re         = 1'b0;
        relay_we        = 1'b0;
        relay_re        = 1'b0;
        req.ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    dest_next  = req.dest_node;
                    count_next = req.relay_count;
                    pos_next   = req.relay_position;
                    addr_next  = req.relay_addr;
                    rnd_next   = req.random_slot;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_BAD;
                res_cnt_next    = 4'd0;
                res_li_next     = 3'd0;
                res_addr_next   = '0;
                res_last_next   = 1'b1;
                more_next       = 1'b0;
                state_next      = S_EMIT;
                case (cmd_reg)
                    CMD_INSTALL:
                    begin
                        if (count_reg > CNT_IN_W'(MAX_RELAYS))
                        begin
                            open_valid_next = 1'b0;
                        end
                        else
                        begin
                            issue_idx_next = '0;
                            pick_next      = SW'(rnd_mod);
                            found_next     = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_RELAY:
                    begin
                        if (relay_ok)
                        begin
                            relay_we        = 1'b1;
                            res_status_next = ST_OK;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        issue_idx_next = '0;
                        found_next     = 1'b0;
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        res_status_next = ST_BAD;
                    end
                endcase
            end
            S_SCAN:
            begin
                slot_re = (issue_idx_reg != (SW+1)'(ROUTE_SLOTS));
                if (slot_re)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                chk_v_next   = slot_re;
                chk_idx_next = issue_idx_reg[SW-1:0];
                if (chk_v_reg)
                begin
                    if (chk_match)
                    begin
                        pick_next    = chk_idx_reg;
                        found_next   = 1'b1;
                        hit_cnt_next = rd_cnt;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        if (!chk_act && (cmd_reg == CMD_INSTALL))
                        begin
                            pick_next = chk_idx_reg;
                        end
                        if (chk_last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_FIN:
            begin
                res_status_next = ST_OK;
                res_cnt_next    = 4'd0;
                res_li_next     = 3'd0;
                res_addr_next   = '0;
                res_last_next   = 1'b1;
                more_next       = 1'b0;
                state_next      = S_EMIT;
                if (cmd_reg == CMD_INSTALL)
                begin
                    slot_we               = 1'b1;
                    active_next[pick_reg] = 1'b1;
                    open_slot_next        = pick_reg;
                    open_valid_next       = 1'b1;
                    open_count_next       = CW'(count_reg);
                end
                else if (!found_reg)
                begin
                    res_status_next = ST_NOROUTE;
                end
                else if (hit_cnt_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    active_next[pick_reg] = 1'b0;
                    res_cnt_next          = 4'(hit_cnt_reg);
                    res_li_next           = 3'(hit_cnt_reg - 1'b1);
                    res_last_next         = 1'b0;
                    more_next             = 1'b1;
                    k_next                = hit_cnt_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_cnt_next    = res_cnt_reg;
                    out_li_next     = res_li_reg;
                    out_addr_next   = res_addr_reg;
                    out_last_next   = res_last_reg;
                    state_next      = more_reg ? S_RREAD : S_IDLE;
                end
            end
            S_RREAD:
            begin
                relay_re   = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                res_status_next = ST_RELAY;
                res_cnt_next    = 4'd0;
                res_li_next     = 3'd0;
                res_addr_next   = relay_rdata;
                res_last_next   = (k_reg == CW'(1));
                more_next       = (k_reg != CW'(1));
                k_next          = k_reg - 1'b1;
                state_next      = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            open_slot_reg  <= '0;
            open_valid_reg <= 1'b0;
            issue_idx_reg  <= '0;
            chk_v_reg      <= 1'b0;
            found_reg      <= 1'b0;
            more_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            open_slot_reg  <= open_slot_next;
            open_valid_reg <= open_valid_next;
            issue_idx_reg  <= issue_idx_next;
            chk_v_reg      <= chk_v_next;
            found_reg      <= found_next;
            more_reg       <= more_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        open_count_reg <= open_count_next;
        chk_idx_reg    <= chk_idx_next;
        pick_reg       <= pick_next;
        hit_cnt_reg    <= hit_cnt_next;
        k_reg          <= k_next;
        cmd_reg        <= cmd_next;
        dest_reg       <= dest_next;
        count_reg      <= count_next;
        pos_reg        <= pos_next;
        addr_reg       <= addr_next;
        rnd_reg        <= rnd_next;
        res_status_reg <= res_status_next;
        res_cnt_reg    <= res_cnt_next;
        res_li_reg     <= res_li_next;
        res_addr_reg   <= res_addr_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_li_reg     <= out_li_next;
        out_addr_reg   <= out_addr_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.relay_count_res  = out_cnt_reg;
    assign rsp.last_relay_index = out_li_reg;
    assign rsp.relay_addr_res   = out_addr_reg;
    assign rsp.last             = out_last_reg;

`ifndef SYNTHESIS
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_valid_reg |-> (open_count_reg <= CW'(MAX_RELAYS)))
        else $error("open slot relay count above limit");

    a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(slot_we && relay_we))
        else $error("slot and relay memory written in the same cycle");

    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |-> ($past(state_reg) == S_RREAD))
        else $error("relay data captured without a read");

    a_relay_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RREAD) |-> (k_reg != '0))
        else $error("relay read with no relays left");

    a_hit_active: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && (cmd_reg == CMD_LOOKUP) && found_reg)
        |-> active_reg[pick_reg])
        else $error("lookup hit on an inactive slot");
`endif

endmodule

// File: rtl/core/surt_ram.sv
module surt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/sv/single_use_source_route_table_chk.sv
module single_use_source_route_table_chk
    import surt_pkg::*;
#(
    parameter int ROUTE_SLOTS = 8,
    parameter int MAX_RELAYS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    surt_req_if                          req,
    surt_rsp_if                          rsp,
    output int                           errors,
    output int                           pending,
    output logic [ROUTE_SLOTS-1:0]       route_on,
    output node_t [ROUTE_SLOTS-1:0]      route_dest,
    output logic [ROUTE_SLOTS-1:0]       route_full
);

    typedef struct packed {
        status_t    status;
        logic [3:0] hops;
        logic [2:0] top_idx;
        node_t      addr;
        logic       last;
    } reply_t;

    reply_t     replies_due[$];
    logic [3:0] route_len [ROUTE_SLOTS];
    node_t      relay_mem [ROUTE_SLOTS*MAX_RELAYS];
    logic       relay_set [ROUTE_SLOTS*MAX_RELAYS];
    int         open_idx;
    logic       open_on;

    function automatic reply_t reply(status_t s, logic [3:0] h, logic [2:0] ti, node_t a,
                                     logic l);
        reply_t x;
        x.status  = s;
        x.hops    = h;
        x.top_idx = ti;
        x.addr    = a;
        x.last    = l;
        return x;
    endfunction

    task automatic table_step(cmd_t c, node_t d, count_t n, pos_t p, node_t a, rnd_t r);
        int pick;
        int hit;
        int len;
        int s;
        int k;
        case (c)
            CMD_INSTALL:
            begin
                if (n > MAX_RELAYS)
                begin
                    open_on = 1'b0;
                    replies_due.push_back(reply(ST_BAD, '0, '0, '0, 1'b1));
                end
                else
                begin
                    pick = int'(r) % ROUTE_SLOTS;
                    for (s = 0; s < ROUTE_SLOTS; s++)
                    begin
                        if (!route_on[s])
                            pick = s;
                        else if (route_dest[s] == d)
                        begin
                            pick = s;
                            break;
                        end
                    end
                    route_dest[pick] = d;
                    route_len[pick]  = 4'(n);
                    route_on[pick]   = 1'b1;
                    open_idx         = pick;
                    open_on          = 1'b1;
                    replies_due.push_back(reply(ST_OK, '0, '0, '0, 1'b1));
                end
            end
            CMD_RELAY:
            begin
                if (open_on && p < route_len[open_idx] && p < MAX_RELAYS)
                begin
                    relay_mem[open_idx*MAX_RELAYS + int'(p)] = a;
                    relay_set[open_idx*MAX_RELAYS + int'(p)] = 1'b1;
                    replies_due.push_back(reply(ST_OK, '0, '0, '0, 1'b1));
                end
                else
                    replies_due.push_back(reply(ST_BAD, '0, '0, '0, 1'b1));
            end
            CMD_LOOKUP:
            begin
                hit = -1;
                for (s = 0; s < ROUTE_SLOTS; s++)
                begin
                    if (route_on[s] && route_dest[s] == d)
                    begin
                        hit = s;
                        break;
                    end
                end
                if (hit < 0)
                    replies_due.push_back(reply(ST_NOROUTE, '0, '0, '0, 1'b1));
                else
                begin
                    len = (route_len[hit] > MAX_RELAYS) ? MAX_RELAYS : int'(route_len[hit]);
                    if (len == 0)
                        replies_due.push_back(reply(ST_EMPTY, '0, '0, '0, 1'b1));
                    else
                    begin
                        route_on[hit] = 1'b0;
                        replies_due.push_back(reply(ST_OK, 4'(len), 3'(len - 1), '0, 1'b0));
                        for (k = 0; k < len; k++)
                            replies_due.push_back(reply(ST_RELAY, '0, '0,
                                relay_mem[hit*MAX_RELAYS + len - 1 - k], k == len - 1));
                    end
                end
            end
            default:
                replies_due.push_back(reply(ST_BAD, '0, '0, '0, 1'b1));
        endcase
        for (s = 0; s < ROUTE_SLOTS; s++)
        begin
            route_full[s] = 1'b1;
            for (k = 0; k < int'(route_len[s]) && k < MAX_RELAYS; k++)
                if (!relay_set[s*MAX_RELAYS + k])
                    route_full[s] = 1'b0;
        end
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got = reply(rsp.status, rsp.relay_count_res, rsp.last_relay_index,
                    rsp.relay_addr_res, rsp.last);
        if (replies_due.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: unexpected result: status %0d count %0d index %0d addr %h last %b",
                         $time, got.status, got.hops, got.top_idx, got.addr, got.last);
            errors++;
        end
        else
        begin
            want = replies_due.pop_front();
            if (got.status !== want.status || got.hops !== want.hops
                || got.top_idx !== want.top_idx || got.addr !== want.addr
                || got.last !== want.last)
            begin
                if (errors < 10)
                    $display("%0t: mismatch: expected status %0d count %0d index %0d addr %h last %b, got status %0d count %0d index %0d addr %h last %b",
                             $time, want.status, want.hops, want.top_idx, want.addr,
                             want.last, got.status, got.hops, got.top_idx, got.addr,
                             got.last);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_due.delete();
            route_on   = '0;
            route_dest = '0;
            route_full = '1;
            for (int s = 0; s < ROUTE_SLOTS; s++)
                route_len[s] = '0;
            for (int k = 0; k < ROUTE_SLOTS*MAX_RELAYS; k++)
            begin
                relay_mem[k] = '0;
                relay_set[k] = 1'b0;
            end
            open_idx = 0;
            open_on  = 1'b0;
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_reply();
            if (req.valid && req.ready)
                table_step(req.cmd, req.dest_node, req.relay_count, req.relay_position,
                           req.relay_addr, req.random_slot);
            pending = replies_due.size();
        end
    end

endmodule

// File: tb/sv/single_use_source_route_table_top_tb.sv
module single_use_source_route_table_top_tb;
    import surt_pkg::*;

    localparam int   ROUTE_SLOTS = 8;
    localparam int   MAX_RELAYS  = 8;
    localparam cmd_t CMD_UNKNOWN = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    surt_req_if req_ch ();
    surt_rsp_if rsp_ch ();

    int                       chk_errors;
    int                       chk_pending;
    logic [ROUTE_SLOTS-1:0]   live;
    node_t [ROUTE_SLOTS-1:0]  live_dest;
    logic [ROUTE_SLOTS-1:0]   live_full;

    int    snd_pct     = 0;
    int    rcv_pct     = 0;
    int    hold_tag    = 0;
    int    hold_cycles = 0;
    int    hold_seen   = 0;
    int    hold_left   = 0;
    logic  rcv_ready   = 1'b0;
    node_t pool [4];

    always #1 clk = ~clk;

    single_use_source_route_table_top #(
        .ROUTE_SLOTS (ROUTE_SLOTS),
        .MAX_RELAYS  (MAX_RELAYS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    single_use_source_route_table_chk #(
        .ROUTE_SLOTS (ROUTE_SLOTS),
        .MAX_RELAYS  (MAX_RELAYS)
    ) i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .errors     (chk_errors),
        .pending    (chk_pending),
        .route_on   (live),
        .route_dest (live_dest),
        .route_full (live_full)
    );

    assign rsp_ch.ready = rcv_ready;

    always @(negedge clk)
    begin
        if (hold_tag != hold_seen)
        begin
            hold_seen = hold_tag;
            hold_left = hold_cycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rcv_ready <= 1'b0;
        end
        else
            rcv_ready <= ($urandom_range(0, 99) >= rcv_pct);
    end

    initial
    begin
        #2000000;
        $display("** single_use_source_route_table_top: FAILED **");
        $finish;
    end

    task automatic send_beat(cmd_t c, node_t d, count_t n, pos_t p, node_t a, rnd_t r);
        while ($urandom_range(0, 99) < snd_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= c;
        req_ch.dest_node      <= d;
        req_ch.relay_count    <= n;
        req_ch.relay_position <= p;
        req_ch.relay_addr     <= a;
        req_ch.random_slot    <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    function automatic node_t pool_dest();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic node_t lookup_dest();
        int tries;
        int i;
        if ($urandom_range(0, 99) < 60)
            for (tries = 0; tries < 16; tries++)
            begin
                i = $urandom_range(0, ROUTE_SLOTS - 1);
                if (live[i])
                    return live_dest[i];
            end
        return ($urandom_range(0, 3) == 0) ? node_t'($urandom) : pool_dest();
    endfunction

    // a lookup may only consume a route whose relays have all been written
    function automatic logic lookup_ok(node_t d);
        int i;
        for (i = 0; i < ROUTE_SLOTS; i++)
            if (live[i] && live_dest[i] == d)
                return live_full[i];
        return 1'b1;
    endfunction

    task automatic random_beats(int total);
        int    sent;
        int    r;
        int    k;
        int    stop;
        int    up;
        node_t d;
        count_t n;
        sent = 0;
        while (sent < total)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                n = count_t'($urandom_range(0, MAX_RELAYS));
                send_beat(CMD_INSTALL, pool_dest(), n, pos_t'($urandom), node_t'($urandom),
                          rnd_t'($urandom));
                sent++;
                stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(n)) : int'(n);
                up   = $urandom_range(0, 1);
                for (k = 0; k < stop; k++)
                begin
                    send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom),
                              pos_t'(up ? k : int'(n) - 1 - k), node_t'($urandom),
                              rnd_t'($urandom));
                    sent++;
                end
            end
            else if (r < 70)
            begin
                d = lookup_dest();
                while (!lookup_ok(d))
                    d = node_t'($urandom);
                send_beat(CMD_LOOKUP, d, count_t'($urandom), pos_t'($urandom),
                          node_t'($urandom), rnd_t'($urandom));
                sent++;
            end
            else if (r < 82)
            begin
                send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom),
                          pos_t'($urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom),
                          node_t'($urandom), rnd_t'($urandom));
                sent++;
            end
            else if (r < 92)
            begin
                send_beat(CMD_INSTALL, pool_dest(),
                          count_t'($urandom_range(MAX_RELAYS + 1, 255)),
                          pos_t'($urandom), node_t'($urandom), rnd_t'($urandom));
                sent++;
            end
            else
            begin
                send_beat(CMD_UNKNOWN, node_t'($urandom), count_t'($urandom), pos_t'($urandom),
                          node_t'($urandom), rnd_t'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int k;
        int waited;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = CMD_INSTALL;
        req_ch.dest_node      = '0;
        req_ch.relay_count    = '0;
        req_ch.relay_position = '0;
        req_ch.relay_addr     = '0;
        req_ch.random_slot    = '0;
        for (k = 0; k < 4; k++)
            pool[k] = node_t'($urandom);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(CMD_LOOKUP, 16'h0000, count_t'($urandom), pos_t'($urandom),
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom), 8'd0,
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_INSTALL, 16'hFFFF, 8'd8, pos_t'($urandom), node_t'($urandom), 3'd0);
        for (k = 0; k < MAX_RELAYS; k++)
            send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom), pos_t'(k),
                      (k == 0) ? 16'h0000 : (k == MAX_RELAYS - 1) ? 16'hFFFF
                                                                 : node_t'($urandom),
                      rnd_t'($urandom));
        send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom), 8'd255,
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_INSTALL, 16'h0000, 8'd0, pos_t'($urandom), node_t'($urandom), 3'd7);
        send_beat(CMD_LOOKUP, 16'h0000, count_t'($urandom), pos_t'($urandom),
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_INSTALL, 16'h0000, 8'd255, pos_t'($urandom), node_t'($urandom),
                  rnd_t'($urandom));
        send_beat(CMD_RELAY, node_t'($urandom), count_t'($urandom), 8'd0,
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_UNKNOWN, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 3'd7);
        send_beat(CMD_LOOKUP, 16'hFFFF, count_t'($urandom), pos_t'($urandom),
                  node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_LOOKUP, 16'hFFFF, count_t'($urandom), pos_t'($urandom),
                  node_t'($urandom), rnd_t'($urandom));
        // fill every slot, then force the random pick
        for (k = 0; k < ROUTE_SLOTS - 1; k++)
            send_beat(CMD_INSTALL, pool[k % 4] + node_t'(k), 8'd0, pos_t'($urandom),
                      node_t'($urandom), rnd_t'($urandom));
        send_beat(CMD_INSTALL, 16'h8000, 8'd0, pos_t'($urandom), node_t'($urandom),
                  rnd_t'($urandom));
        drain();

        for (k = 0; k < 4; k++)
        begin
            snd_pct = (k == 1) ? 77 : (k == 3) ? 6 : 0;
            rcv_pct <= (k == 2) ? 77 : (k == 3) ? 6 : 0;
            random_beats(15);
            drain();
        end

        // hold the receiver off while beats keep coming
        snd_pct = 0;
        rcv_pct <= 0;
        hold_cycles <= 400;
        hold_tag <= hold_tag + 1;
        random_beats(10);
        drain();

        waited = 0;
        while (chk_pending != 0 && waited < 20000)
        begin
            waited++;
            @(negedge clk);
        end
        repeat (60) @(negedge clk);
        if (chk_errors == 0 && chk_pending == 0)
            $display("** single_use_source_route_table_top: PASSED **");
        else
            $display("** single_use_source_route_table_top: FAILED **");
        $finish;
    end

endmodule
